// ===== hw/rtl/tsbhc_pkg.sv =====
// Package for the cascaded biquad high-pass filter: sequencer states,
// tap and register codes, fixed-point constants and coefficient resets.
// No dependencies.
package tsbhc_pkg;

   localparam int CHAN_BITS      = 3;
   localparam int COEF_BITS      = 32;
   localparam int COEF_FRAC      = 29;
   localparam int BYPASS_BITS    = 4;
   localparam int CSR_INDEX_BITS = 3;
   localparam int HIST_WORDS     = 4;
   localparam int NUM_TAPS       = 5;
   localparam int TAP_BITS       = 3;

   typedef logic signed [COEF_BITS-1:0] coef_type;

   // Tap order matches the coefficient register order.
   localparam logic [TAP_BITS-1:0] TAP_X  = 3'd0;
   localparam logic [TAP_BITS-1:0] TAP_X1 = 3'd1;
   localparam logic [TAP_BITS-1:0] TAP_X2 = 3'd2;
   localparam logic [TAP_BITS-1:0] TAP_Y1 = 3'd3;
   localparam logic [TAP_BITS-1:0] TAP_Y2 = 3'd4;
   localparam logic [TAP_BITS-1:0] TAP_END = 3'd5;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_B0 = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_B1 = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_B2 = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_A1 = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_A2 = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BYPASS  = 3'd5;

   // About 95 Hz, Q 0.7071 at 48 kHz, Q2.29.
   localparam coef_type COEF_RESET [NUM_TAPS] = '{
      32'sd532170607, -32'sd1064341214, 32'sd532170607,
      -32'sd1064300412, 32'sd527511641
   };

   localparam logic [BYPASS_BITS-1:0] BYPASS_RESET = 4'hF;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_ROUND,
      ST_EMIT
   } state_type;

endpackage

// ===== hw/rtl/tsbhc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsbhc_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 24
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]        wr_data,
   input  logic                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/three_stage_biquad_highpass_cascade_top.sv =====
// Top level of the cascaded biquad high-pass filter: sequencer, shared
// multiply-accumulate datapath, history RAM and CSR block.
// Depends on tsbhc_pkg and tsbhc_ram.
//
// Usage:
//  - req_ channel: one beat per sample (channel, sample, frame end flag).
//    req_ready is high only while the sequencer is idle.
//  - rsp_ channel: one beat per request, in order, held in an output
//    register until rsp_ready; a new request is taken while it waits.
//  - csr_ channel: register writes (index 0..4 coefficients b0 b1 b2 a1
//    a2, index 5 bypass channel); always ready, write only while idle.
//  - Sequence: each section runs the five taps through the shared 32xN
//    multiplier and its accumulator, then rounds, saturates and writes
//    back; after the last section the output register is loaded.
//    Bypassed or out-of-range channels go straight to the output register.
//  - Reset: coefficients return to the 95 Hz defaults, bypass to none,
//    and every history row is marked empty (reads as zero) at once.
//  - Stall: if rsp_ready stays low, the finished sample waits in the
//    sequencer and no new request is taken.
module three_stage_biquad_highpass_cascade_top #(
   parameter int CHANNELS    = 8,
   parameter int SECTIONS    = 3,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [tsbhc_pkg::CHAN_BITS-1:0]          req_channel_index,
   input  logic signed [SAMPLE_BITS-1:0]            req_sample_in,
   input  logic                                     req_frame_end_in,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [tsbhc_pkg::CHAN_BITS-1:0]          rsp_channel_out,
   output logic signed [SAMPLE_BITS-1:0]            rsp_sample_out,
   output logic                                     rsp_frame_end_out,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [tsbhc_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [tsbhc_pkg::COEF_BITS-1:0]          csr_wdata
);

   import tsbhc_pkg::*;

   localparam int SB       = SAMPLE_BITS;
   localparam int HIST_W   = HIST_WORDS * SB;
   localparam int ROWS     = CHANNELS * SECTIONS;
   localparam int ROW_BITS = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int SEC_BITS = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
   localparam int PROD_W   = COEF_BITS + SB;
   localparam int ACC_W    = PROD_W + 3;
   localparam int RND_W    = ACC_W - COEF_FRAC;
   localparam int RANGE_W  = 6;

   localparam logic [SEC_BITS-1:0] LAST_SEC = SEC_BITS'(SECTIONS - 1);
   localparam logic signed [ACC_W-1:0] RND_BIAS =
      {{(ACC_W - COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC - 1){1'b0}}};
   localparam logic signed [RND_W-1:0] SAT_HI =
      {{(RND_W - SB + 1){1'b0}}, {(SB - 1){1'b1}}};
   localparam logic signed [RND_W-1:0] SAT_LO =
      {{(RND_W - SB + 1){1'b1}}, {(SB - 1){1'b0}}};

   // Sequencer and datapath registers
   state_type                  state_ff, state_in;
   logic [CHAN_BITS-1:0]       ch_ff, ch_in;
   logic                       fe_ff, fe_in;
   logic signed [SB-1:0]       x_ff, x_in;
   logic [ROW_BITS-1:0]        row_ff, row_in;
   logic [SEC_BITS-1:0]        sec_ff, sec_in;
   logic [TAP_BITS-1:0]        tap_ff, tap_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic                       prod_sub_ff, prod_sub_in;
   logic                       rd_valid_ff, rd_valid_in;
   logic [ROWS-1:0]            row_valid_ff, row_valid_in;

   // Output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [CHAN_BITS-1:0]       rsp_ch_ff, rsp_ch_in;
   logic signed [SB-1:0]       rsp_sample_ff, rsp_sample_in;
   logic                       rsp_fe_ff, rsp_fe_in;

   // Configuration registers
   coef_type                   coef_ff [NUM_TAPS];
   coef_type                   coef_in [NUM_TAPS];
   logic [BYPASS_BITS-1:0]     bypass_ff, bypass_in;

   // Control and datapath wires
   logic                       accept;
   logic                       filter_req;
   logic                       last_sec;
   logic                       emit_load;
   logic                       ram_rd_en;
   logic                       ram_wr_en;
   logic [ROW_BITS-1:0]        row_base;
   logic [ROW_BITS-1:0]        rd_addr;
   logic [HIST_W-1:0]          rd_data;
   logic [HIST_W-1:0]          hist;
   logic [HIST_W-1:0]          wr_data;
   logic signed [SB-1:0]       h0, h1, h2, h3;
   logic signed [SB-1:0]       op_sel;
   coef_type                   coef_sel;
   logic signed [ACC_W-1:0]    rnd_sum;
   logic signed [RND_W-1:0]    rnd_q;
   logic signed [SB-1:0]       y_sat;

   // ------------------------------------------------------------------
   // Request decode: filter only in-range channels that are not bypassed
   // ------------------------------------------------------------------
   assign accept     = req_valid & req_ready;
   assign filter_req = ({{(RANGE_W - CHAN_BITS){1'b0}}, req_channel_index}
                          < RANGE_W'(CHANNELS))
                       && !(!bypass_ff[BYPASS_BITS-1]
                            && bypass_ff[CHAN_BITS-1:0] == req_channel_index);
   assign row_base   = ROW_BITS'(32'(req_channel_index) * SECTIONS);
   assign last_sec   = (sec_ff == LAST_SEC);

   // ------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = filter_req ? ST_MAC : ST_EMIT;
            end
         end
         ST_MAC: begin
            if (tap_ff == TAP_END) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            state_in = last_sec ? ST_EMIT : ST_MAC;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // Sequencer outputs
   // ------------------------------------------------------------------
   always_comb begin
      req_ready = 1'b0;
      ram_rd_en = 1'b0;
      ram_wr_en = 1'b0;
      emit_load = 1'b0;
      rd_addr   = row_base;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ram_rd_en = req_valid & filter_req;
         end
         ST_MAC: begin
         end
         ST_ROUND: begin
            // Write back this section, fetch the next one's row.
            ram_wr_en = 1'b1;
            ram_rd_en = !last_sec;
            rd_addr   = row_ff + 1'b1;
         end
         ST_EMIT: begin
            emit_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Shared multiply-accumulate datapath
   // ------------------------------------------------------------------
   // Rows never written read as zero.
   assign hist = rd_valid_ff ? rd_data : '0;
   assign h0   = hist[SB-1:0];
   assign h1   = hist[2*SB-1:SB];
   assign h2   = hist[3*SB-1:2*SB];
   assign h3   = hist[4*SB-1:3*SB];

   always_comb begin
      case (tap_ff)
         TAP_X:   op_sel = x_ff;
         TAP_X1:  op_sel = h0;
         TAP_X2:  op_sel = h1;
         TAP_Y1:  op_sel = h2;
         TAP_Y2:  op_sel = h3;
         default: op_sel = '0;
      endcase
   end

   assign coef_sel = (tap_ff < TAP_END) ? coef_ff[tap_ff] : '0;

   // Round half up at Q1.23, then clamp.
   assign rnd_sum = acc_ff + RND_BIAS;
   assign rnd_q   = $signed(rnd_sum[ACC_W-1:COEF_FRAC]);

   always_comb begin
      if (rnd_q > SAT_HI) begin
         y_sat = SAT_HI[SB-1:0];
      end else if (rnd_q < SAT_LO) begin
         y_sat = SAT_LO[SB-1:0];
      end else begin
         y_sat = rnd_q[SB-1:0];
      end
   end

   // Shift history: x2 <- x1, x1 <- x, y2 <- y1, y1 <- y.
   assign wr_data = {h2, y_sat, h0, x_ff};

   always_comb begin
      ch_in       = ch_ff;
      fe_in       = fe_ff;
      x_in        = x_ff;
      row_in      = row_ff;
      sec_in      = sec_ff;
      tap_in      = tap_ff;
      acc_in      = acc_ff;
      prod_in     = prod_ff;
      prod_sub_in = prod_sub_ff;
      rd_valid_in = rd_valid_ff;
      row_valid_in = row_valid_ff;

      if (ram_rd_en) begin
         rd_valid_in = row_valid_ff[rd_addr];
      end
      if (ram_wr_en) begin
         row_valid_in[row_ff] = 1'b1;
      end

      if (accept) begin
         ch_in  = req_channel_index;
         fe_in  = req_frame_end_in;
         x_in   = req_sample_in;
         row_in = row_base;
         sec_in = '0;
         tap_in = TAP_X;
         acc_in = '0;
      end

      if (state_ff == ST_MAC) begin
         // Multiply tap n while adding the product of tap n-1.
         if (tap_ff != TAP_END) begin
            prod_in     = coef_sel * op_sel;
            prod_sub_in = (tap_ff == TAP_Y1) || (tap_ff == TAP_Y2);
            tap_in      = tap_ff + 1'b1;
         end
         if (tap_ff != TAP_X) begin
            acc_in = prod_sub_ff ? acc_ff - ACC_W'(prod_ff)
                                 : acc_ff + ACC_W'(prod_ff);
         end
      end

      if (state_ff == ST_ROUND) begin
         // Section output feeds the next section, or the result.
         x_in = y_sat;
         if (!last_sec) begin
            row_in = row_ff + 1'b1;
            sec_in = sec_ff + 1'b1;
            tap_in = TAP_X;
            acc_in = '0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------
   always_comb begin
      rsp_valid_in  = emit_load | (rsp_valid_ff & ~rsp_ready);
      rsp_ch_in     = rsp_ch_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_fe_in     = rsp_fe_ff;
      if (emit_load) begin
         rsp_ch_in     = ch_ff;
         rsp_sample_in = x_ff;
         rsp_fe_in     = fe_ff;
      end
   end

   // ------------------------------------------------------------------
   // CSR writes
   // ------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_comb begin
      coef_in   = coef_ff;
      bypass_in = bypass_ff;
      if (csr_valid) begin
         unique case (csr_index) inside
            CSR_COEF_B0, CSR_COEF_B1, CSR_COEF_B2, CSR_COEF_A1, CSR_COEF_A2: begin
               coef_in[csr_index] = csr_wdata;
            end
            CSR_BYPASS: begin
               bypass_in = csr_wdata[BYPASS_BITS-1:0];
            end
            default: begin
               // Drop writes beyond the register list.
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         row_valid_ff <= '0;
         coef_ff      <= COEF_RESET;
         bypass_ff    <= BYPASS_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         row_valid_ff <= row_valid_in;
         coef_ff      <= coef_in;
         bypass_ff    <= bypass_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff         <= ch_in;
      fe_ff         <= fe_in;
      x_ff          <= x_in;
      row_ff        <= row_in;
      sec_ff        <= sec_in;
      tap_ff        <= tap_in;
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      prod_sub_ff   <= prod_sub_in;
      rd_valid_ff   <= rd_valid_in;
      rsp_ch_ff     <= rsp_ch_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_fe_ff     <= rsp_fe_in;
   end

   // ------------------------------------------------------------------
   // History RAM: one row per channel and section, x1 x2 y1 y2 packed
   // ------------------------------------------------------------------
   tsbhc_ram #(
      .WIDTH (HIST_W),
      .DEPTH (ROWS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (row_ff),
      .wr_data (wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_channel_out   = rsp_ch_ff;
   assign rsp_sample_out    = rsp_sample_ff;
   assign rsp_frame_end_out = rsp_fe_ff;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for three_stage_biquad_highpass_cascade_top: directed and random
// samples over several coefficient settings, checked against a fixed-point cascade model.
// Depends on tsbhc_pkg and the filter RTL; reads no files.
module tb_top;
   import tsbhc_pkg::*;

   localparam int NUM_CHANNELS = 8;
   localparam int NUM_SECTIONS = 3;
   localparam int SAMPLE_W     = 24;

   // Both sides idle at random with a chance of about one in six; the cycle limit leaves
   // a wide margin for the ~1900 beats that the tests send.
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_BEATS  = 270;

   // History words per channel and section
   localparam int HIST_X1 = 0;
   localparam int HIST_X2 = 1;
   localparam int HIST_Y1 = 2;
   localparam int HIST_Y2 = 3;

   // Register indexes past the list; writes to them must be dropped
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HI = 3'd7;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   localparam sample_type SAMPLE_HI  = 24'sh7FFFFF;
   localparam sample_type SAMPLE_LO  = 24'sh800000;
   localparam longint  SAMPLE_MAX = 8388607;
   localparam longint  SAMPLE_MIN = -8388608;
   localparam longint  ROUND_HALF = 64'sd1 <<< (COEF_FRAC - 1);
   localparam coef_type COEF_ONE  = 32'sd1 <<< COEF_FRAC;

   typedef struct packed {
      logic [CHAN_BITS-1:0] channel;
      sample_type           sample;
      logic                 frame_end;
   } audio_beat_type;

   typedef struct packed {
      coef_type b0;
      coef_type b1;
      coef_type b2;
      coef_type a1;
      coef_type a2;
   } coef_set_type;

   typedef enum int {
      SET_DEFAULT,
      SET_UNITY,
      SET_MAX,
      SET_MIN,
      SET_ZERO,
      SET_RANDOM,
      SET_NEAR_DEFAULT,
      SET_COUNT
   } setting_kind_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [CHAN_BITS-1:0]      req_channel_index;
   sample_type                req_sample_in;
   logic                      req_frame_end_in;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [CHAN_BITS-1:0]      rsp_channel_out;
   sample_type                rsp_sample_out;
   logic                      rsp_frame_end_out;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [COEF_BITS-1:0]      csr_wdata;

   // Mirror of the block's registers and per-channel section history
   coef_type                  coef_bank [NUM_TAPS];
   logic signed [BYPASS_BITS-1:0] bypass_sel;
   sample_type                section_taps [NUM_CHANNELS][NUM_SECTIONS][HIST_WORDS];

   audio_beat_type            pending_outputs [$];
   int                        fail_count;
   int                        cycle_count;
   bit                        calm_stretch;

   three_stage_biquad_highpass_cascade_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_channel_index (req_channel_index),
      .req_sample_in     (req_sample_in),
      .req_frame_end_in  (req_frame_end_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_channel_out   (rsp_channel_out),
      .rsp_sample_out    (rsp_sample_out),
      .rsp_frame_end_out (rsp_frame_end_out),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   task automatic clear_filter_state();
      for (int t = 0; t < NUM_TAPS; t++) coef_bank[t] = COEF_RESET[t];
      bypass_sel = BYPASS_RESET;
      for (int c = 0; c < NUM_CHANNELS; c++)
         for (int s = 0; s < NUM_SECTIONS; s++)
            for (int w = 0; w < HIST_WORDS; w++) section_taps[c][s][w] = '0;
   endtask

   // One direct-form-I section: exact products, exact sum, round half up to
   // Q1.23, saturate. The saturated value is also what goes into y1.
   function automatic sample_type run_biquad(input int ch, input int sec,
                                             input sample_type x);
      longint     acc;
      sample_type y;
      acc = longint'(coef_bank[TAP_X])  * longint'(x)
          + longint'(coef_bank[TAP_X1]) * longint'(section_taps[ch][sec][HIST_X1])
          + longint'(coef_bank[TAP_X2]) * longint'(section_taps[ch][sec][HIST_X2])
          - longint'(coef_bank[TAP_Y1]) * longint'(section_taps[ch][sec][HIST_Y1])
          - longint'(coef_bank[TAP_Y2]) * longint'(section_taps[ch][sec][HIST_Y2]);
      // Arithmetic shift of a signed value is the floor division we want
      acc = (acc + ROUND_HALF) >>> COEF_FRAC;
      if (acc > SAMPLE_MAX)
         y = SAMPLE_HI;
      else if (acc < SAMPLE_MIN)
         y = SAMPLE_LO;
      else
         y = sample_type'(acc);
      section_taps[ch][sec][HIST_X2] = section_taps[ch][sec][HIST_X1];
      section_taps[ch][sec][HIST_X1] = x;
      section_taps[ch][sec][HIST_Y2] = section_taps[ch][sec][HIST_Y1];
      section_taps[ch][sec][HIST_Y1] = y;
      return y;
   endfunction

   // Whole cascade for one sample. A negative bypass setting matches no channel,
   // and a bypassed channel leaves its history untouched.
   function automatic sample_type filter_cascade(input logic [CHAN_BITS-1:0] ch,
                                                 input sample_type s);
      sample_type v;
      v = s;
      if (int'(ch) < NUM_CHANNELS && int'(bypass_sel) != int'(ch))
         for (int sec = 0; sec < NUM_SECTIONS; sec++) v = run_biquad(int'(ch), sec, v);
      return v;
   endfunction

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // Send one sample beat. Valid is left high after acceptance; the next call
   // either reuses it or drops it during an idle gap.
   task automatic send_sample(input int ch, input sample_type s, input logic fe);
      audio_beat_type beat;
      while (!calm_stretch && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_channel_index <= CHAN_BITS'(ch);
      req_sample_in     <= s;
      req_frame_end_in  <= fe;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beat.channel   = CHAN_BITS'(ch);
      beat.sample    = filter_cascade(CHAN_BITS'(ch), s);
      beat.frame_end = fe;
      pending_outputs.push_back(beat);
   endtask

   // Drop valid and hold until every predicted beat has been checked.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (pending_outputs.size() != 0);
   endtask

   // Write one register; valid stays high for a following write and is
   // dropped by the caller once the batch is done.
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [COEF_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx <= CSR_COEF_A2)
         coef_bank[idx] = coef_type'(data);
      else if (idx == CSR_BYPASS)
         bypass_sel = data[BYPASS_BITS-1:0];
   endtask

   // Write every register while the filter is idle, plus a dropped write now and then.
   task automatic apply_setting(input coef_set_type cs, input logic [BYPASS_BITS-1:0] byp);
      logic [COEF_BITS-1:0] junk;
      wait_until_drained();
      junk = $urandom();
      write_csr(CSR_COEF_B0, cs.b0);
      write_csr(CSR_COEF_B1, cs.b1);
      write_csr(CSR_COEF_B2, cs.b2);
      write_csr(CSR_COEF_A1, cs.a1);
      write_csr(CSR_COEF_A2, cs.a2);
      write_csr(CSR_BYPASS, {junk[COEF_BITS-1:BYPASS_BITS], byp});
      if ($urandom_range(1))
         write_csr($urandom_range(1) ? CSR_SPARE_HI : CSR_SPARE_LO, $urandom());
      csr_valid <= 1'b0;
   endtask

   function automatic sample_type pick_sample();
      int v;
      v = $urandom_range(2000) - 1000;
      case ($urandom_range(9))
         0:       return SAMPLE_HI;
         1:       return SAMPLE_LO;
         2, 3:    return sample_type'(v);
         default: return sample_type'($urandom());
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Result side: random stalls and in-order checking
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else if (calm_stretch)
         rsp_ready <= 1'b1;
      else
         rsp_ready <= ($urandom_range(99) >= 16);
   end

   always @(posedge clock) begin : check_result
      audio_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outputs.size() == 0) begin
            $error("unexpected beat: channel %0d sample %0d frame_end %0b",
                   rsp_channel_out, $signed(rsp_sample_out), rsp_frame_end_out);
            fail_count++;
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_channel_out !== want.channel) begin
               $error("channel_out: expected %0d, actual %0d", want.channel, rsp_channel_out);
               fail_count++;
            end
            if (rsp_sample_out !== want.sample) begin
               $error("sample_out: expected %0d, actual %0d",
                      $signed(want.sample), $signed(rsp_sample_out));
               fail_count++;
            end
            if (rsp_frame_end_out !== want.frame_end) begin
               $error("frame_end_out: expected %0b, actual %0b",
                      want.frame_end, rsp_frame_end_out);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset coefficients, no bypass: full-scale swings push every section into
   // saturation, then each channel gets one beat with the marker on the last, and the last channel one more.
   task automatic test_directed_extremes();
      send_sample(0, '0, 1'b0);
      send_sample(0, SAMPLE_HI, 1'b0);
      send_sample(0, SAMPLE_LO, 1'b0);
      send_sample(0, SAMPLE_HI, 1'b0);
      send_sample(0, SAMPLE_LO, 1'b0);
      send_sample(0, -24'sd1, 1'b0);
      send_sample(0, 24'sd1, 1'b1);
      for (int c = 0; c < NUM_CHANNELS; c++)
         send_sample(c, (c % 2) ? SAMPLE_LO : SAMPLE_HI, c == NUM_CHANNELS - 1);
      send_sample(NUM_CHANNELS - 1, SAMPLE_HI, 1'b1);
      wait_until_drained();
   endtask

   // Bypass one channel, move the bypass, then clear it with a negative value.
   // Channel 3 resumes filtering on the history it had before bypass.
   task automatic test_bypass_channel();
      logic [COEF_BITS-1:0] junk;
      junk = $urandom();
      write_csr(CSR_BYPASS, {junk[COEF_BITS-1:BYPASS_BITS], 4'd3});
      csr_valid <= 1'b0;
      send_sample(3, SAMPLE_HI, 1'b0);
      send_sample(3, SAMPLE_LO, 1'b1);
      send_sample(2, SAMPLE_HI, 1'b0);
      wait_until_drained();
      junk = $urandom();
      write_csr(CSR_BYPASS, {junk[COEF_BITS-1:BYPASS_BITS], 4'd7});
      csr_valid <= 1'b0;
      send_sample(7, 24'sd12345, 1'b1);
      send_sample(3, SAMPLE_HI, 1'b0);
      wait_until_drained();
      junk = $urandom();
      write_csr(CSR_BYPASS, {junk[COEF_BITS-1:BYPASS_BITS], 4'h8});
      write_csr(CSR_SPARE_LO, $urandom());
      write_csr(CSR_SPARE_HI, $urandom());
      csr_valid <= 1'b0;
      send_sample(7, SAMPLE_LO, 1'b0);
      send_sample(0, SAMPLE_HI, 1'b1);
      wait_until_drained();
   endtask

   // Mostly whole frames (channels in order, marker on the last), some stray
   // beats, and an occasional pause until everything has come back.
   task automatic stream_random_audio(input int count);
      int sent;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 80) begin
            for (int c = 0; c < NUM_CHANNELS; c++)
               send_sample(c, pick_sample(), c == NUM_CHANNELS - 1);
            sent += NUM_CHANNELS;
         end else begin
            send_sample($urandom_range(NUM_CHANNELS - 1), pick_sample(),
                        1'($urandom_range(1)));
            sent++;
         end
         if ($urandom_range(99) < 3) wait_until_drained();
      end
   endtask

   // Walk through coefficient settings, extremes included, with random traffic.
   task automatic test_setting_sweep();
      coef_set_type     cs;
      setting_kind_type kind;
      int               jitter [NUM_TAPS];
      for (int k = 0; k < SET_COUNT; k++) begin
         kind = setting_kind_type'(k);
         for (int t = 0; t < NUM_TAPS; t++) jitter[t] = $urandom_range(65535) - 32768;
         case (kind)
            SET_DEFAULT:
               cs = {COEF_RESET[TAP_X], COEF_RESET[TAP_X1], COEF_RESET[TAP_X2],
                     COEF_RESET[TAP_Y1], COEF_RESET[TAP_Y2]};
            SET_UNITY:
               cs = {COEF_ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
            SET_MAX:
               cs = {5{32'h7FFF_FFFF}};
            SET_MIN:
               cs = {5{32'h8000_0000}};
            SET_ZERO:
               cs = '0;
            SET_RANDOM:
               cs = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
            default:
               cs = {coef_type'(COEF_RESET[TAP_X]  + jitter[0]),
                     coef_type'(COEF_RESET[TAP_X1] + jitter[1]),
                     coef_type'(COEF_RESET[TAP_X2] + jitter[2]),
                     coef_type'(COEF_RESET[TAP_Y1] + jitter[3]),
                     coef_type'(COEF_RESET[TAP_Y2] + jitter[4])};
         endcase
         apply_setting(cs, BYPASS_BITS'($urandom_range(15)));
         // Pass-through phase runs with no idling on either side
         calm_stretch = (kind == SET_UNITY);
         stream_random_audio(PHASE_BEATS);
         calm_stretch = 1'b0;
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_channel_index <= '0;
      req_sample_in     <= '0;
      req_frame_end_in  <= 1'b0;
      csr_valid         <= 1'b0;
      csr_index         <= '0;
      csr_wdata         <= '0;
      calm_stretch      = 1'b0;
      clear_filter_state();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_directed_extremes();
      test_bypass_channel();
      test_setting_sweep();

      wait_until_drained();
      // Let any stray beat show up before the verdict
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
